// ===== hdl/modular_inverse_ext_euclid_defines.svh =====
// Assertion macros for the modular inverse block.
// No dependencies; included by the top level only.
`ifndef MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define MODINV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset
`define MODINV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MODINV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MODINV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/modinv_pkg.sv =====
// Shared types for the modular inverse block: sequencer states and
// the command/status groups between controller and datapath. No dependencies.
package modinv_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } modinv_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture modulus and value, seed coefficients
        logic div_init;  // start a division of old by current remainder
        logic div_step;  // one quotient bit and one coefficient accumulate
        logic update;    // rotate remainders and coefficients
        logic finish;    // load the result register
    } modinv_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cur_zero;  // current remainder is zero
    } modinv_stat_t;

endpackage

// ===== hdl/modinv_ctrl.sv =====
// Sequencer for the modular inverse block: rounds, division bit count,
// handshakes. Depends on modinv_pkg.
module modinv_ctrl #(
    parameter int WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  modinv_pkg::modinv_stat_t stat,
    output modinv_pkg::modinv_cmd_t  cmd
);
    import modinv_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    modinv_state_t    state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // State, bit counter and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_ready        = 1'b0;

        // drop the result once it has been transferred
        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.cur_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = CNT_W'(WIDTH - 1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                // hold until the result register is free
                if (!out_valid_reg || m_ready) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== hdl/modinv_dpath.sv =====
// Datapath for the modular inverse block: remainders, signed-magnitude
// coefficients, restoring divider with coefficient accumulate, result register.
// Depends on modinv_pkg.
module modinv_dpath #(
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic [WIDTH-1:0]         s_modulus,
    input  logic [WIDTH-1:0]         s_value,
    input  modinv_pkg::modinv_cmd_t  cmd,
    output modinv_pkg::modinv_stat_t stat,
    output logic [WIDTH-1:0]         m_inverse,
    output logic                     m_coprime
);
    import modinv_pkg::*;

    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] rem_old_reg, rem_cur_reg;
    logic [WIDTH-1:0] mag_old_reg, mag_cur_reg;
    logic             neg_old_reg, neg_cur_reg;
    logic [WIDTH-1:0] part_reg, part_next;
    logic [WIDTH-1:0] dvd_reg;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] inv_reg, inv_next;
    logic             cop_reg;

    logic [WIDTH:0]   rem_shift;
    logic [WIDTH+1:0] diff;
    logic             qbit;

    // One restoring division step; accumulate q * current magnitude MSB first
    always_comb begin
        rem_shift = {part_reg, dvd_reg[WIDTH-1]};
        diff      = {1'b0, rem_shift} - {2'b00, rem_cur_reg};
        qbit      = !diff[WIDTH+1];
        part_next = qbit ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
        acc_next  = {acc_reg[WIDTH-2:0], 1'b0} + (qbit ? mag_cur_reg : '0);
    end

    // Fold a negative coefficient back into range
    always_comb begin
        if (neg_old_reg && (mag_old_reg != '0)) begin
            inv_next = mod_reg - mag_old_reg;
        end else begin
            inv_next = mag_old_reg;
        end
    end

    // Euclid state
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mod_reg     <= s_modulus;
            rem_old_reg <= s_modulus;
            rem_cur_reg <= s_value;
            mag_old_reg <= '0;
            mag_cur_reg <= WIDTH'(1);
            neg_old_reg <= 1'b0;
            neg_cur_reg <= 1'b0;
        end else if (cmd.update) begin
            rem_old_reg <= rem_cur_reg;
            rem_cur_reg <= part_reg;
            mag_old_reg <= mag_cur_reg;
            mag_cur_reg <= acc_reg + mag_old_reg;
            neg_old_reg <= neg_cur_reg;
            neg_cur_reg <= !neg_cur_reg;
        end
    end

    // Divider registers
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            part_reg <= '0;
            dvd_reg  <= rem_old_reg;
            acc_reg  <= '0;
        end else if (cmd.div_step) begin
            part_reg <= part_next;
            dvd_reg  <= {dvd_reg[WIDTH-2:0], 1'b0};
            acc_reg  <= acc_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            inv_reg <= inv_next;
            cop_reg <= (rem_old_reg == WIDTH'(1));
        end
    end

    assign stat.cur_zero = (rem_cur_reg == '0);
    assign m_inverse     = inv_reg;
    assign m_coprime     = cop_reg;

endmodule

// ===== hdl/modular_inverse_ext_euclid.sv =====
// Modular inverse by the extended Euclidean algorithm; uses modinv_pkg.
// Each Euclid round (0 .. about 1.44*WIDTH+2 rounds in all) is one pass of the
// shared bit-serial divider over all WIDTH quotient bits, plus a check and an
// update state. One item in flight; a new input is taken only after the last
// result has been loaded into the result register.
// Reset (synchronous, aresetn low) returns to idle and drops any pending result.
`include "modular_inverse_ext_euclid_defines.svh"

module modular_inverse_ext_euclid #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [WIDTH-1:0] s_modulus,
    input  logic [WIDTH-1:0] s_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_inverse,
    output logic             m_coprime
);
    import modinv_pkg::*;

    modinv_cmd_t  cmd;
    modinv_stat_t stat;

    // Sequencer
    modinv_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic
    modinv_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .s_modulus (s_modulus),
        .s_value   (s_value),
        .cmd       (cmd),
        .stat      (stat),
        .m_inverse (m_inverse),
        .m_coprime (m_coprime)
    );

    // Only one item in flight
    `MODINV_ASSERT_NXT(a_single_item, aclk, aresetn, s_valid && s_ready, !s_ready, "busy")
    // Result never overwrites an untransferred one
    `MODINV_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.finish, !m_valid || m_ready, "overwrite")
    // Divider never runs on a zero divisor
    `MODINV_ASSERT_IMP(a_div_nonzero, aclk, aresetn, cmd.div_init || cmd.div_step, !stat.cur_zero, "div0")

endmodule
